>>> rtl/pgcf_pkg.sv
// Shared constants and types for the PNG gAMA chunk finder.
`default_nettype none
package pgcf_pkg;

  localparam int unsigned CAPTURE_BYTES  = 16;  // bytes kept from the gAMA chunk start
  localparam int unsigned SIG_BYTES      = 8;
  localparam int unsigned HEAD_BYTES     = 8;
  localparam int unsigned CHUNK_OVERHEAD = 12;  // length, type and CRC fields
  localparam int unsigned CNT_W          = $clog2(CAPTURE_BYTES + 1);
  localparam int unsigned TAIL_SHIFT     = ((16 - CAPTURE_BYTES) * 8) % 64;

  localparam logic [31:0] TYPE_GAMA = 32'h67414D41;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_IEND    = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_NO_GAMA = 2'd3
  } status_e;

  typedef struct packed {
    logic        found;
    logic [63:0] chunk_head;
    logic [63:0] chunk_tail;
    status_e     status;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/pgcf_if.sv
// Stream interfaces for the byte input and the result output.
`default_nettype none
interface pgcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pgcf_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] chunk_head;
  logic [63:0] chunk_tail;
  logic [1:0]  status;

  modport source (output valid, output found, output chunk_head, output chunk_tail,
                  output status, input ready);
  modport sink   (input valid, input found, input chunk_head, input chunk_tail,
                  input status, output ready);
endinterface
`default_nettype wire

>>> rtl/pgcf_parser.sv
// Chunk walker: tracks offsets and chunk boundaries and captures the gAMA chunk.
`default_nettype none
module pgcf_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  output logic                  res_valid_o,
  output pgcf_pkg::result_t     res_o
);
  import pgcf_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG, PH_HEADER, PH_SKIP, PH_CAPTURE, PH_IEND_WAIT, PH_DONE
  } phase_e;

  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPTURE_BYTES);
  localparam logic [CNT_W-1:0] HEAD_CNT = CNT_W'(HEAD_BYTES);

  phase_e           phase_q, phase_d;
  logic [31:0]      offset_q, offset_d;
  logic [32:0]      ncs_q, ncs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  status_e          outcome_q, outcome_d;
  logic [63:0]      hdr_q, hdr_d, head_q, head_d, tail_q, tail_d;

  logic [32:0]      here_end;
  logic             reached;
  logic [63:0]      hdr_shift;
  logic [CNT_W-1:0] cnt_inc, cnt_cap;
  logic [33:0]      end_sum;
  logic             hdr_done;
  logic             cap_more;
  status_e          status;

  assign here_end  = {1'b0, offset_q} + 33'd1;
  assign reached   = here_end >= ncs_q;
  assign hdr_shift = {hdr_q[55:0], data_byte_i};
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign end_sum   = {1'b0, ncs_q} + 34'(CHUNK_OVERHEAD) + {2'b00, hdr_shift[63:32]};
  assign cap_more  = cnt_q < CAP_CNT;
  assign cnt_cap   = cap_more ? cnt_inc : cnt_q;

  always_comb begin
    phase_d   = phase_q;
    ncs_d     = ncs_q;
    cnt_d     = cnt_q;
    outcome_d = outcome_q;
    hdr_d     = hdr_q;
    head_d    = head_q;
    tail_d    = tail_q;
    hdr_done  = 1'b0;
    offset_d  = (offset_q != '1) ? offset_q + 32'd1 : offset_q;
    unique case (phase_q)
      PH_SIG, PH_SKIP: begin
        if (reached) begin
          phase_d = PH_HEADER;
          cnt_d   = '0;
        end
      end
      PH_HEADER: begin
        hdr_d = hdr_shift;
        cnt_d = cnt_inc;
        if (cnt_inc >= HEAD_CNT) begin
          // The chunk end saturates rather than wrapping.
          ncs_d    = end_sum[33] ? '1 : end_sum[32:0];
          hdr_done = 1'b1;
          if (hdr_shift[31:0] == TYPE_GAMA) begin
            head_d  = hdr_shift;
            tail_d  = '0;
            phase_d = PH_CAPTURE;
          end else if (hdr_shift[31:0] == TYPE_IEND) begin
            phase_d = PH_IEND_WAIT;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_CAPTURE: begin
        if (cap_more) begin
          tail_d = {tail_q[55:0], data_byte_i};
          cnt_d  = cnt_inc;
        end
        if (cnt_cap >= CAP_CNT && reached) begin
          outcome_d = ST_FOUND;
          phase_d   = PH_DONE;
        end
      end
      PH_IEND_WAIT: begin
        if (reached) begin
          outcome_d = ST_IEND;
          phase_d   = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (hdr_done || phase_d == PH_SIG || phase_d == PH_HEADER) begin
      status = ST_NO_GAMA;
    end else if (phase_d == PH_DONE) begin
      status = outcome_d;
    end else begin
      status = ST_TRUNC;
    end
    res_valid_o      = accept_i && last_byte_i;
    res_o.status     = status;
    res_o.found      = (status == ST_FOUND);
    res_o.chunk_head = res_o.found ? head_d : '0;
    res_o.chunk_tail = res_o.found ? (tail_d << TAIL_SHIFT) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIG;
      offset_q  <= '0;
      ncs_q     <= 33'(SIG_BYTES);
      cnt_q     <= '0;
      outcome_q <= ST_NO_GAMA;
    end else if (accept_i) begin
      if (last_byte_i) begin
        // The next transaction starts a new file.
        phase_q   <= PH_SIG;
        offset_q  <= '0;
        ncs_q     <= 33'(SIG_BYTES);
        cnt_q     <= '0;
        outcome_q <= ST_NO_GAMA;
      end else begin
        phase_q   <= phase_d;
        offset_q  <= offset_d;
        ncs_q     <= ncs_d;
        cnt_q     <= cnt_d;
        outcome_q <= outcome_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hdr_q  <= hdr_d;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pgcf_out_buf.sv
// Result register with a skid stage so input bytes keep flowing during output stalls.
`default_nettype none
module pgcf_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire pgcf_pkg::result_t push_data_i,
  output logic                   ready_o,
  pgcf_out_if.source             out_o
);
  import pgcf_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    take;
  logic    main_load;

  assign take      = main_valid_q && out_o.ready;
  assign main_load = !main_valid_q || take;
  assign ready_o   = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_load) begin
      main_valid_q <= skid_valid_q || push_i;
      skid_valid_q <= skid_valid_q && push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_load) begin
      main_q <= skid_valid_q ? skid_q : push_data_i;
      if (skid_valid_q && push_i) begin
        skid_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign out_o.valid      = main_valid_q;
  assign out_o.found      = main_q.found;
  assign out_o.chunk_head = main_q.chunk_head;
  assign out_o.chunk_tail = main_q.chunk_tail;
  assign out_o.status     = main_q.status;

endmodule
`default_nettype wire

>>> rtl/png_gamma_chunk_finder.sv
// Top level of the streaming PNG chunk walker that reports the first gAMA chunk.
//
//   Channel  Dir  Payload                                   Transaction
//   in_i     in   data_byte[7:0], last_byte                 one file byte
//   out_o    out  found, chunk_head[63:0], chunk_tail[63:0],  one result per file,
//                 status[1:0]                               after the last byte
//
// One byte is taken every cycle while the skid stage is empty; each byte updates the
// walker state in a single pass (an offset compare, one 34-bit chunk end add and a
// shift). A file's result enters the result register, or the skid stage while that
// register is held; up to two results are held, so input only stalls when both are
// occupied. Reset is asynchronous and active low and needs no clearing pass.
`default_nettype none
module png_gamma_chunk_finder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pgcf_in_if.sink    in_i,
  pgcf_out_if.source out_o
);
  import pgcf_pkg::*;

  logic    accept;
  logic    res_valid;
  logic    buf_ready;
  result_t res;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  pgcf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pgcf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire
